// ----- hdl/almc_pkg.sv -----
// ----------------------------------------------------------------------------
// almc_pkg: shared types and constants of the alert LED and motor controller
// Event and result payloads, command bytes, codes and register reset values.
// ----------------------------------------------------------------------------
package almc_pkg;

	// Event kinds
	typedef enum logic [1:0] {
		ACT_COMMAND = 2'd0,
		ACT_TICK    = 2'd1,
		ACT_EXPIRY  = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	// Motor pattern codes
	typedef enum logic [1:0] {
		PAT_OFF     = 2'd0,
		PAT_WARNING = 2'd1,
		PAT_DANGER  = 2'd2,
		PAT_ALERT   = 2'd3
	} pattern_t;

	// Chosen color codes
	typedef enum logic [1:0] {
		COL_NONE   = 2'd0,
		COL_GREEN  = 2'd1,
		COL_ORANGE = 2'd2,
		COL_RED    = 2'd3
	} color_t;

	// Command bytes from the wireless link
	localparam logic [7:0] CMD_GREEN  = 8'h59;
	localparam logic [7:0] CMD_ORANGE = 8'h58;
	localparam logic [7:0] CMD_RED    = 8'h5A;
	localparam logic [7:0] CMD_ALERT  = 8'h40;
	localparam logic [7:0] CMD_STOP   = 8'h26;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORANGE_CYCLE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORANGE_SLOTS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WARN_TOGGLES   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DANGER_PERIODS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WARN_RELOAD    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_RELOAD    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_RELOAD   = 3'd7;

	// Register reset values
	localparam logic [9:0]  RST_BLINK_PERIOD   = 10'd800;
	localparam logic [5:0]  RST_ORANGE_CYCLE   = 6'd20;
	localparam logic [5:0]  RST_ORANGE_SLOTS   = 6'd1;
	localparam logic [7:0]  RST_WARN_TOGGLES   = 8'd100;
	localparam logic [7:0]  RST_DANGER_PERIODS = 8'd2;
	localparam logic [15:0] RST_WARN_RELOAD    = 16'h0280;
	localparam logic [15:0] RST_LONG_RELOAD    = 16'hFFFF;
	localparam logic [15:0] RST_SHORT_RELOAD   = 16'h8000;
	localparam logic [15:0] RST_RELOAD_VALUE   = 16'd20000;

	// One event
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] command_byte;
	} almc_evt_t;

	// One result
	typedef struct packed {
		logic        led_red;
		logic        led_green;
		logic        motor_drive;
		logic [15:0] timer_reload;
		logic [1:0]  motor_pattern;
	} almc_res_t;

endpackage

// ----- hdl/alert_led_motor_controller_unit.sv -----
// ----------------------------------------------------------------------------
// alert_led_motor_controller_unit: alert LED and vibration motor controller
// Applies command, LED tick and motor expiry events to the LED/motor state
// and reports the state after each event.
// ----------------------------------------------------------------------------
// Path: an accepted event is held in the event register, then its result is
// written to the result register, where it waits for its transfer.
// Throughput: one event per cycle while res_ready is high; the state update is a single short pass.
// Reset: arst_n clears the controller state and valid flags and loads the default register values;
// the timer reload value starts at 20000 and no result is pending.
module alert_led_motor_controller_unit (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       evt_valid,
	output logic                                       evt_ready,
	input  almc_pkg::almc_evt_t                        evt,
	output logic                                       res_valid,
	input  logic                                       res_ready,
	output almc_pkg::almc_res_t                        res,
	input  logic                                       cfg_we,
	input  logic [almc_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [almc_pkg::CFG_DATA_W-1:0]            cfg_data
);

	// Configuration registers
	logic [9:0]  blink_period_q;
	logic [5:0]  orange_cycle_q;
	logic [5:0]  orange_slots_q;
	logic [7:0]  warn_toggles_q;
	logic [7:0]  danger_periods_q;
	logic [15:0] warn_reload_q;
	logic [15:0] long_reload_q;
	logic [15:0] short_reload_q;

	// Controller state
	almc_pkg::color_t   color_q, color_d;
	almc_pkg::pattern_t pattern_q, pattern_d;
	logic        alert_q, alert_d;
	logic        motor_q, motor_d;
	logic        red_q, red_d;
	logic        green_q, green_d;
	logic [15:0] reload_q, reload_d;
	logic [7:0]  pcount_q, pcount_d;
	logic [9:0]  blink_q, blink_d;
	logic [5:0]  phase_q, phase_d;

	// Event stage and result register
	logic                 evt_valid_s1;
	almc_pkg::almc_evt_t  evt_s1;
	logic                 res_valid_q;
	almc_pkg::almc_res_t  res_q;
	logic                 advance;

	// Tick helpers
	logic        mix;
	logic [6:0]  phase_inc;
	logic [10:0] blink_inc;

	// Move the event stage into the result register when there is room
	assign advance   = evt_valid_s1 && (!res_valid_q || res_ready);
	assign evt_ready = !evt_valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q   <= almc_pkg::RST_BLINK_PERIOD;
			orange_cycle_q   <= almc_pkg::RST_ORANGE_CYCLE;
			orange_slots_q   <= almc_pkg::RST_ORANGE_SLOTS;
			warn_toggles_q   <= almc_pkg::RST_WARN_TOGGLES;
			danger_periods_q <= almc_pkg::RST_DANGER_PERIODS;
			warn_reload_q    <= almc_pkg::RST_WARN_RELOAD;
			long_reload_q    <= almc_pkg::RST_LONG_RELOAD;
			short_reload_q   <= almc_pkg::RST_SHORT_RELOAD;
		end else if (cfg_we) begin
			case (cfg_index)
				almc_pkg::REG_BLINK_PERIOD:   blink_period_q   <= cfg_data[9:0];
				almc_pkg::REG_ORANGE_CYCLE:   orange_cycle_q   <= cfg_data[5:0];
				almc_pkg::REG_ORANGE_SLOTS:   orange_slots_q   <= cfg_data[5:0];
				almc_pkg::REG_WARN_TOGGLES:   warn_toggles_q   <= cfg_data[7:0];
				almc_pkg::REG_DANGER_PERIODS: danger_periods_q <= cfg_data[7:0];
				almc_pkg::REG_WARN_RELOAD:    warn_reload_q    <= cfg_data;
				almc_pkg::REG_LONG_RELOAD:    long_reload_q    <= cfg_data;
				almc_pkg::REG_SHORT_RELOAD:   short_reload_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture an event on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			evt_valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			evt_s1 <= evt;
		end
	end

	// Tick counters wrap past their register value
	assign mix       = phase_q < orange_slots_q;
	assign phase_inc = {1'b0, phase_q} + 7'd1;
	assign blink_inc = {1'b0, blink_q} + 11'd1;

	// Compute the state after the staged event
	always_comb begin
		color_d   = color_q;
		pattern_d = pattern_q;
		alert_d   = alert_q;
		motor_d   = motor_q;
		red_d     = red_q;
		green_d   = green_q;
		reload_d  = reload_q;
		pcount_d  = pcount_q;
		blink_d   = blink_q;
		phase_d   = phase_q;
		case (almc_pkg::action_t'(evt_s1.action))
			almc_pkg::ACT_COMMAND: begin
				case (evt_s1.command_byte)
					almc_pkg::CMD_GREEN: begin
						if (color_q != almc_pkg::COL_GREEN) begin
							color_d = almc_pkg::COL_GREEN;
							red_d   = 1'b0;
							green_d = 1'b1;
							if (!alert_q) begin
								motor_d   = 1'b0;
								pattern_d = almc_pkg::PAT_OFF;
							end
						end
					end
					almc_pkg::CMD_ORANGE: begin
						if (color_q != almc_pkg::COL_ORANGE) begin
							color_d = almc_pkg::COL_ORANGE;
							red_d   = 1'b1;
							green_d = 1'b0;
							if (!alert_q) begin
								motor_d   = 1'b1;
								pattern_d = almc_pkg::PAT_WARNING;
								reload_d  = warn_reload_q;
							end
						end
					end
					almc_pkg::CMD_RED: begin
						if (color_q != almc_pkg::COL_RED) begin
							color_d = almc_pkg::COL_RED;
							red_d   = 1'b1;
							green_d = 1'b0;
							if (!alert_q) begin
								motor_d   = 1'b1;
								pattern_d = almc_pkg::PAT_DANGER;
								reload_d  = long_reload_q;
							end
						end
					end
					almc_pkg::CMD_ALERT: begin
						if (!alert_q) begin
							motor_d   = 1'b1;
							pattern_d = almc_pkg::PAT_ALERT;
							reload_d  = long_reload_q;
							alert_d   = 1'b1;
						end
					end
					almc_pkg::CMD_STOP: begin
						if (alert_q) begin
							motor_d   = 1'b0;
							pattern_d = almc_pkg::PAT_OFF;
							reload_d  = '0;
							alert_d   = 1'b0;
						end
					end
					default: ;
				endcase
			end
			almc_pkg::ACT_TICK: begin
				if (alert_q) begin
					// Blink the chosen color, keep orange mixing between toggles
					if (blink_q == blink_period_q) begin
						if (color_q == almc_pkg::COL_GREEN) begin
							green_d = !green_q;
						end else if (color_q == almc_pkg::COL_ORANGE ||
							color_q == almc_pkg::COL_RED) begin
							red_d = !red_q;
						end
					end else if (color_q == almc_pkg::COL_ORANGE) begin
						green_d = mix && red_q;
					end
				end else begin
					// Hold the chosen color
					case (color_q)
						almc_pkg::COL_GREEN: green_d = 1'b1;
						almc_pkg::COL_ORANGE: begin
							red_d   = 1'b1;
							green_d = mix;
						end
						almc_pkg::COL_RED: red_d = 1'b1;
						default: ;
					endcase
				end
				phase_d = (phase_inc > {1'b0, orange_cycle_q}) ? 6'd0 : phase_inc[5:0];
				blink_d = (blink_inc > {1'b0, blink_period_q}) ? 10'd0 : blink_inc[9:0];
			end
			almc_pkg::ACT_EXPIRY: begin
				case (pattern_q)
					almc_pkg::PAT_WARNING: begin
						if (pcount_q >= warn_toggles_q) begin
							motor_d   = 1'b0;
							pattern_d = almc_pkg::PAT_OFF;
							reload_d  = '0;
							pcount_d  = 8'd1;
						end else begin
							motor_d  = !motor_q;
							pcount_d = pcount_q + 8'd1;
						end
					end
					almc_pkg::PAT_DANGER: begin
						if (pcount_q >= danger_periods_q) begin
							motor_d   = 1'b0;
							pattern_d = almc_pkg::PAT_OFF;
							reload_d  = '0;
							pcount_d  = 8'd1;
						end else begin
							pcount_d = pcount_q + 8'd1;
						end
					end
					almc_pkg::PAT_ALERT: begin
						// Alternate long motor-on and short motor-off periods
						if (reload_q == long_reload_q) begin
							motor_d  = 1'b0;
							reload_d = short_reload_q;
						end else begin
							motor_d  = 1'b1;
							reload_d = long_reload_q;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Advance state on each event leaving the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q   <= almc_pkg::COL_NONE;
			pattern_q <= almc_pkg::PAT_OFF;
			alert_q   <= 1'b0;
			motor_q   <= 1'b0;
			red_q     <= 1'b0;
			green_q   <= 1'b0;
			reload_q  <= almc_pkg::RST_RELOAD_VALUE;
			pcount_q  <= '0;
			blink_q   <= '0;
			phase_q   <= '0;
		end else if (advance) begin
			color_q   <= color_d;
			pattern_q <= pattern_d;
			alert_q   <= alert_d;
			motor_q   <= motor_d;
			red_q     <= red_d;
			green_q   <= green_d;
			reload_q  <= reload_d;
			pcount_q  <= pcount_d;
			blink_q   <= blink_d;
			phase_q   <= phase_d;
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.led_red       <= red_d;
			res_q.led_green     <= green_d;
			res_q.motor_drive   <= motor_d;
			res_q.timer_reload  <= reload_d;
			res_q.motor_pattern <= pattern_d;
		end
	end

	// Motor is never driven with the pattern off
	a_off_no_motor: assert property (@(posedge clk) disable iff (!arst_n)
		pattern_q == almc_pkg::PAT_OFF |-> !motor_q)
		else $error("motor driven with pattern off");

	// Alert flag and alert pattern go together
	a_alert_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		alert_q == (pattern_q == almc_pkg::PAT_ALERT))
		else $error("alert flag and pattern disagree");

	// A full event stage only takes a new event when it drains
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && evt_valid_s1 |-> advance)
		else $error("event stage overwritten");

	// A staged event always produces a pending result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result lost after advance");

endmodule
